// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/core/sts_pkg.sv =====
// Types, constants and helper functions for the SQL token scanner.
package sts_pkg;

  // Position counter width and saturation value
  localparam int POS_BITS = 16;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  // Field widths
  localparam int LEN_BITS = 16;
  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};
  localparam int WORD_CHARS = 6;
  localparam int WORD_BITS = 8 * WORD_CHARS;
  localparam int NUM_KEYWORDS = 12;

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_WORD = 3'd1,
    MODE_NUM  = 3'd2,
    MODE_STR  = 3'd3,
    MODE_OP   = 3'd4
  } scan_mode_e;

  typedef enum logic [2:0] {
    KIND_KEYWORD = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_NUMBER  = 3'd2,
    KIND_STRING  = 3'd3,
    KIND_OPER    = 3'd4,
    KIND_PUNCT   = 3'd5,
    KIND_WILD    = 3'd6,
    KIND_END     = 3'd7
  } tok_kind_e;

  // One result item
  typedef struct packed {
    tok_kind_e           kind;
    logic [3:0]          kw;
    logic [15:0]         start;
    logic [LEN_BITS-1:0] len;
    logic [7:0]          sym;
    logic                eq;
    logic                ovf;
    logic                last;
  } tok_t;

  // Keywords, upper case, first character in the low byte
  localparam logic [WORD_BITS-1:0] KW_TEXT [NUM_KEYWORDS] = '{
    48'h5443454C4553,  // SELECT
    48'h545245534E49,  // INSERT
    48'h4554454C4544,  // DELETE
    48'h00004D4F5246,  // FROM
    48'h004552454857,  // WHERE
    48'h00004F544E49,  // INTO
    48'h5345554C4156,  // VALUES
    48'h455441455243,  // CREATE
    48'h00454C424154,  // TABLE
    48'h000000544E49,  // INT
    48'h474E49525453,  // STRING
    48'h0000504F5244   // DROP
  };
  localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{
    3'd6, 3'd6, 3'd6, 3'd4, 3'd5, 3'd4, 3'd6, 3'd6, 3'd5, 3'd3, 3'd6, 3'd4
  };

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [LEN_BITS-1:0] sat_inc(input logic [LEN_BITS-1:0] v);
    return (v == LEN_MAX) ? v : v + 1'b1;
  endfunction

  // Place an upper-cased letter at byte lane len, only within the first six
  function automatic logic [WORD_BITS-1:0] add_letter(input logic [WORD_BITS-1:0] w,
                                                      input logic [LEN_BITS-1:0] len,
                                                      input logic [7:0] c);
    logic [WORD_BITS-1:0] r;
    logic [7:0]           u;
    r = w;
    u = (c >= 8'h61 && c <= 8'h7A) ? c - CASE_GAP : c;
    for (int i = 0; i < WORD_CHARS; i++) begin
      if (len == LEN_BITS'(i)) r[8*i +: 8] = r[8*i +: 8] | u;
    end
    return r;
  endfunction

  // Keyword code of an open word, zero when none matches
  function automatic logic [3:0] kw_lookup(input logic [WORD_BITS-1:0] w,
                                           input logic [LEN_BITS-1:0] len);
    logic [3:0] code;
    code = 4'd0;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      if (len == LEN_BITS'(KW_LEN[k]) && w == KW_TEXT[k]) code = 4'(k + 1);
    end
    return code;
  endfunction

endpackage

// ===== rtl/core/sql_token_scanner_core.sv =====
// Streaming SQL lexer core: one character per transfer in, tokens out.
//
// Input channel: in_valid_i / in_stall_o with cmd_i (0 = character, 1 = end of
// input) and ch_i. Output channel: out_valid_o / out_stall_i with one token per
// transfer: kind, keyword code, start offset, length, symbol, with_equals,
// overflowed and last_of_run (set on the final token caused by one input).
// Each input gives zero, one or two tokens.
// An accepted item waits in the input register and is scanned there; once the
// queue has room its tokens are written to the token queue, whose head is offered.
// Throughput: one item per cycle while the queue has room. The output side
// drains one token per cycle, so an item that closes a token and emits another,
// or an end item that flushes an open token, gives two tokens; the four-entry
// queue absorbs these bursts, and the input stalls only when it has room for
// fewer than two tokens. Reset clears the scan state, the position counter
// and the queue; no token is pending afterward. While out_stall_i is high the
// head token holds and items keep entering until the input stalls.
// The end item flushes an open token, emits the end token and returns the
// scanner to idle; the position keeps counting across queries.
`include "assert_macros.svh"

module sql_token_scanner_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  token_kind_o,
  output logic [3:0]  keyword_code_o,
  output logic [15:0] start_offset_o,
  output logic [15:0] token_length_o,
  output logic [7:0]  symbol_char_o,
  output logic        with_equals_o,
  output logic        overflowed_o,
  output logic        last_of_run_o
);

  // Input register
  logic       s1_valid_q, s1_valid_d;
  logic       s1_cmd_q;
  logic [7:0] s1_ch_q;

  // Scan state
  sts_pkg::scan_mode_e                mode_q, mode_d;
  logic [sts_pkg::POS_BITS-1:0]       start_q, start_d;
  logic [sts_pkg::LEN_BITS-1:0]       len_q, len_d;
  logic [sts_pkg::WORD_BITS-1:0]      letters_q, letters_d;
  logic [7:0]                         pend_q, pend_d;
  logic [sts_pkg::POS_BITS-1:0]       pos_q, pos_d;

  // Token queue
  sts_pkg::tok_t                      fifo_q [sts_pkg::FIFO_DEPTH];
  logic [sts_pkg::FIFO_AW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [sts_pkg::FIFO_CW-1:0]        cnt_q;

  logic                               room, advance, in_xfer, pop;
  logic                               close_v, fresh_v, consumed, ovf;
  logic [sts_pkg::POS_BITS-1:0]       p_next;
  sts_pkg::tok_t                      close_tok, fresh_tok, first_tok;
  logic [1:0]                         push_cnt;
  sts_pkg::tok_t                      head;

  assign room       = cnt_q <= sts_pkg::FIFO_CW'(sts_pkg::FIFO_DEPTH - 2);
  assign advance    = s1_valid_q && room;
  assign in_stall_o = s1_valid_q && !room;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;
  assign s1_valid_d = in_xfer ? 1'b1 : (advance ? 1'b0 : s1_valid_q);

  // Input register load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_cmd_q <= cmd_i;
      s1_ch_q  <= ch_i;
    end
  end

  // Token for whatever is open now, with the given overflow flag
  function automatic sts_pkg::tok_t close_rec(input sts_pkg::scan_mode_e m,
                                              input logic [sts_pkg::POS_BITS-1:0] st,
                                              input logic [sts_pkg::LEN_BITS-1:0] ln,
                                              input logic [sts_pkg::WORD_BITS-1:0] w,
                                              input logic [7:0] ps,
                                              input logic of);
    sts_pkg::tok_t t;
    logic [3:0]    kw;
    t       = '0;
    t.start = 16'(st);
    t.len   = ln;
    t.ovf   = of;
    kw      = sts_pkg::kw_lookup(w, ln);
    case (m)
      sts_pkg::MODE_WORD: begin
        t.kind = (kw != 4'd0) ? sts_pkg::KIND_KEYWORD : sts_pkg::KIND_IDENT;
        t.kw   = kw;
      end
      sts_pkg::MODE_NUM: t.kind = sts_pkg::KIND_NUMBER;
      sts_pkg::MODE_STR: t.kind = sts_pkg::KIND_STRING;
      sts_pkg::MODE_OP: begin
        t.kind = sts_pkg::KIND_OPER;
        t.len  = sts_pkg::LEN_BITS'(1);
        t.sym  = ps;
      end
      default: t.kind = sts_pkg::KIND_END;
    endcase
    return t;
  endfunction

  // Scan one item: next state and up to two tokens
  always_comb begin
    mode_d    = mode_q;
    start_d   = start_q;
    len_d     = len_q;
    letters_d = letters_q;
    pend_d    = pend_q;
    pos_d     = pos_q;
    close_v   = 1'b0;
    fresh_v   = 1'b0;
    consumed  = 1'b0;
    fresh_tok = '0;
    ovf       = (pos_q == sts_pkg::POS_MAX);
    p_next    = ovf ? pos_q : pos_q + 1'b1;
    close_tok = close_rec(mode_q, start_q, len_q, letters_q, pend_q, ovf);

    if (s1_cmd_q) begin
      // End of input: flush, then the end token
      close_tok       = close_rec(mode_q, start_q, len_q, letters_q, pend_q, 1'b0);
      close_v         = (mode_q == sts_pkg::MODE_WORD) || (mode_q == sts_pkg::MODE_NUM) ||
                        (mode_q == sts_pkg::MODE_STR) || (mode_q == sts_pkg::MODE_OP);
      fresh_v         = 1'b1;
      fresh_tok.kind  = sts_pkg::KIND_END;
      fresh_tok.start = 16'(pos_q);
      mode_d          = sts_pkg::MODE_IDLE;
      len_d           = '0;
      letters_d       = '0;
      pend_d          = '0;
    end else begin
      pos_d = p_next;
      // Continue or close the open token
      case (mode_q)
        sts_pkg::MODE_STR: begin
          consumed = 1'b1;
          if (s1_ch_q == sts_pkg::CH_QUOTE) begin
            close_v = 1'b1;
          end else begin
            len_d = sts_pkg::sat_inc(len_q);
          end
        end
        sts_pkg::MODE_OP: begin
          if (s1_ch_q == sts_pkg::CH_EQ) begin
            consumed      = 1'b1;
            close_v       = 1'b1;
            close_tok.len = sts_pkg::LEN_BITS'(2);
            close_tok.eq  = 1'b1;
          end else begin
            close_v = 1'b1;
          end
        end
        sts_pkg::MODE_WORD: begin
          if (sts_pkg::is_alpha(s1_ch_q) || sts_pkg::is_digit(s1_ch_q) ||
              s1_ch_q == sts_pkg::CH_UNDER) begin
            consumed  = 1'b1;
            letters_d = sts_pkg::add_letter(letters_q, len_q, s1_ch_q);
            len_d     = sts_pkg::sat_inc(len_q);
          end else begin
            close_v = 1'b1;
          end
        end
        sts_pkg::MODE_NUM: begin
          if (sts_pkg::is_digit(s1_ch_q)) begin
            consumed = 1'b1;
            len_d    = sts_pkg::sat_inc(len_q);
          end else begin
            close_v = 1'b1;
          end
        end
        default: mode_d = sts_pkg::MODE_IDLE;
      endcase

      if (close_v) begin
        mode_d    = sts_pkg::MODE_IDLE;
        len_d     = '0;
        letters_d = '0;
        pend_d    = '0;
      end

      // Start a new token from the current character
      if (!consumed) begin
        fresh_tok.start = 16'(pos_q);
        fresh_tok.len   = sts_pkg::LEN_BITS'(1);
        fresh_tok.sym   = s1_ch_q;
        fresh_tok.ovf   = ovf;
        if (sts_pkg::is_alpha(s1_ch_q)) begin
          mode_d    = sts_pkg::MODE_WORD;
          start_d   = pos_q;
          letters_d = sts_pkg::add_letter('0, '0, s1_ch_q);
          len_d     = sts_pkg::LEN_BITS'(1);
        end else if (sts_pkg::is_digit(s1_ch_q)) begin
          mode_d  = sts_pkg::MODE_NUM;
          start_d = pos_q;
          len_d   = sts_pkg::LEN_BITS'(1);
        end else if (s1_ch_q == sts_pkg::CH_QUOTE) begin
          mode_d  = sts_pkg::MODE_STR;
          start_d = p_next;
          len_d   = '0;
        end else if (s1_ch_q == sts_pkg::CH_EQ || s1_ch_q == sts_pkg::CH_LT ||
                     s1_ch_q == sts_pkg::CH_GT || s1_ch_q == sts_pkg::CH_BANG) begin
          mode_d  = sts_pkg::MODE_OP;
          start_d = pos_q;
          pend_d  = s1_ch_q;
        end else if (s1_ch_q == sts_pkg::CH_LPAREN || s1_ch_q == sts_pkg::CH_RPAREN ||
                     s1_ch_q == sts_pkg::CH_COMMA) begin
          fresh_v        = 1'b1;
          fresh_tok.kind = sts_pkg::KIND_PUNCT;
        end else if (s1_ch_q == sts_pkg::CH_STAR) begin
          fresh_v        = 1'b1;
          fresh_tok.kind = sts_pkg::KIND_WILD;
        end
      end
    end

    // Last-of-run goes on the final token of this item
    fresh_tok.last = 1'b1;
    close_tok.last = !fresh_v;
  end

  assign push_cnt  = advance ? ({1'b0, close_v} + {1'b0, fresh_v}) : 2'd0;
  assign first_tok = close_v ? close_tok : fresh_tok;

  // Scan state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= sts_pkg::MODE_IDLE;
      start_q   <= '0;
      len_q     <= '0;
      letters_q <= '0;
      pend_q    <= '0;
      pos_q     <= '0;
    end else if (advance) begin
      mode_q    <= mode_d;
      start_q   <= start_d;
      len_q     <= len_d;
      letters_q <= letters_d;
      pend_q    <= pend_d;
      pos_q     <= pos_d;
    end
  end

  // Token queue pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + sts_pkg::FIFO_AW'(push_cnt);
      rd_ptr_q <= rd_ptr_q + sts_pkg::FIFO_AW'(pop);
      cnt_q    <= cnt_q + sts_pkg::FIFO_CW'(push_cnt) - sts_pkg::FIFO_CW'(pop);
    end
  end

  // Token queue storage
  always_ff @(posedge clk_i) begin
    if (push_cnt != 2'd0) begin
      fifo_q[wr_ptr_q] <= first_tok;
    end
    if (push_cnt == 2'd2) begin
      fifo_q[wr_ptr_q + 1'b1] <= fresh_tok;
    end
  end

  // Output port mapping
  assign head           = fifo_q[rd_ptr_q];
  assign out_valid_o    = cnt_q != '0;
  assign token_kind_o   = head.kind;
  assign keyword_code_o = head.kw;
  assign start_offset_o = head.start;
  assign token_length_o = head.len;
  assign symbol_char_o  = head.sym;
  assign with_equals_o  = head.eq;
  assign overflowed_o   = head.ovf;
  assign last_of_run_o  = head.last;

  // Checks
  `ASSERT_NEVER(a_fifo_over, cnt_q > sts_pkg::FIFO_CW'(sts_pkg::FIFO_DEPTH), "token queue overrun")
  `ASSERT_CLK(a_end_emits, (advance && s1_cmd_q) |-> (push_cnt != 2'd0), "end item emitted nothing")
  `ASSERT_CLK(a_end_idle, (advance && s1_cmd_q) |=> (mode_q == sts_pkg::MODE_IDLE), "not idle after end")
  `ASSERT_CLK(a_pos_mono, (advance && !s1_cmd_q) |=> (pos_q >= $past(pos_q)), "position went back")

endmodule

// ===== sim/sts_checker.sv =====
// Token checker for the SQL token scanner: predicts tokens and compares each output transfer.
`timescale 1ns / 1ps

module sts_checker
  import sts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        cmd_i,
  input  logic [7:0]  ch_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  token_kind_i,
  input  logic [3:0]  keyword_code_i,
  input  logic [15:0] start_offset_i,
  input  logic [15:0] token_length_i,
  input  logic [7:0]  symbol_char_i,
  input  logic        with_equals_i,
  input  logic        overflowed_i,
  input  logic        last_of_run_i,
  output int          fail_count_o,
  output int          pending_count_o
);

  // Keyword spellings, code is index plus one
  string kw_names [12] = '{"SELECT", "INSERT", "DELETE", "FROM", "WHERE", "INTO",
                           "VALUES", "CREATE", "TABLE", "INT", "STRING", "DROP"};

  // Scanner state as the predictor sees it
  scan_mode_e           mode       = MODE_IDLE;
  logic [POS_BITS-1:0]  pos        = '0;
  logic [15:0]          open_start = '0;
  logic [15:0]          open_len   = '0;
  logic [WORD_BITS-1:0] letters    = '0;
  logic [7:0]           op_sym     = '0;

  tok_t predicted_tokens [$];
  tok_t burst [$];
  tok_t exp_tok;
  int   fails = 0;

  function automatic logic char_is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic char_is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic tok_t make_tok(input tok_kind_e kind, input logic [3:0] kw,
                                    input logic [15:0] start, input logic [15:0] len,
                                    input logic [7:0] sym, input logic eq, input logic ovf);
    tok_t t;
    t.kind  = kind;
    t.kw    = kw;
    t.start = start;
    t.len   = len;
    t.sym   = sym;
    t.eq    = eq;
    t.ovf   = ovf;
    t.last  = 1'b0;
    return t;
  endfunction

  // Append one token to the tokens of the current item
  task automatic emit_tok(input tok_t t);
    burst = {burst, t};
  endtask

  // Match the open word against the keyword list by length and letters
  function automatic logic [3:0] keyword_code();
    logic [WORD_BITS-1:0] packed_kw;
    logic [3:0]           code;
    code = 4'd0;
    for (int k = 0; k < 12; k++) begin
      if (open_len == 16'(kw_names[k].len())) begin
        packed_kw = '0;
        for (int i = 0; i < kw_names[k].len(); i++) packed_kw[8*i +: 8] = kw_names[k][i];
        if (packed_kw == letters) code = 4'(k + 1);
      end
    end
    return code;
  endfunction

  // Keep the first six letters upper-cased; length saturates
  task automatic add_letter(input logic [7:0] c);
    logic [7:0] u;
    u = (c >= "a" && c <= "z") ? c - 8'h20 : c;
    if (open_len < 16'd6) letters[8*open_len[2:0] +: 8] = u;
    if (open_len != LEN_MAX) open_len++;
  endtask

  // Emit the open token, if any, and return to idle
  task automatic close_token(input logic ovf);
    logic [3:0] kw;
    case (mode)
      MODE_WORD: begin
        kw = keyword_code();
        emit_tok(make_tok((kw != 4'd0) ? KIND_KEYWORD : KIND_IDENT, kw,
                          open_start, open_len, 8'd0, 1'b0, ovf));
      end
      MODE_NUM: emit_tok(make_tok(KIND_NUMBER, 4'd0, open_start, open_len,
                                  8'd0, 1'b0, ovf));
      MODE_STR: emit_tok(make_tok(KIND_STRING, 4'd0, open_start, open_len,
                                  8'd0, 1'b0, ovf));
      MODE_OP:  emit_tok(make_tok(KIND_OPER, 4'd0, open_start, 16'd1,
                                  op_sym, 1'b0, ovf));
      default: ;
    endcase
    mode     = MODE_IDLE;
    open_len = '0;
    letters  = '0;
    op_sym   = '0;
  endtask

  // Scan one accepted item and queue the tokens it causes
  task automatic scan_item(input logic cmd, input logic [7:0] c);
    logic                ovf;
    logic                taken;
    logic [POS_BITS-1:0] p;
    logic [POS_BITS-1:0] pn;
    tok_t                t;
    ovf   = 1'b0;
    taken = 1'b0;
    burst.delete();
    if (cmd) begin
      close_token(1'b0);
      emit_tok(make_tok(KIND_END, 4'd0, pos, 16'd0, 8'd0, 1'b0, 1'b0));
    end else begin
      // position saturates at its top value
      p  = pos;
      pn = p;
      if (p == POS_MAX) ovf = 1'b1;
      else pn = p + 1'b1;
      pos = pn;

      case (mode)
        MODE_STR: begin
          if (c == CH_QUOTE) close_token(ovf);
          else if (open_len != LEN_MAX) open_len++;
          taken = 1'b1;
        end
        MODE_OP: begin
          if (c == CH_EQ) begin
            emit_tok(make_tok(KIND_OPER, 4'd0, open_start, 16'd2, op_sym, 1'b1, ovf));
            mode   = MODE_IDLE;
            op_sym = '0;
            taken  = 1'b1;
          end else begin
            close_token(ovf);
          end
        end
        MODE_WORD: begin
          if (char_is_letter(c) || char_is_digit(c) || c == CH_UNDER) begin
            add_letter(c);
            taken = 1'b1;
          end else begin
            close_token(ovf);
          end
        end
        MODE_NUM: begin
          if (char_is_digit(c)) begin
            if (open_len != LEN_MAX) open_len++;
            taken = 1'b1;
          end else begin
            close_token(ovf);
          end
        end
        default: mode = MODE_IDLE;
      endcase

      // the closing character is scanned on its own
      if (!taken) begin
        if (char_is_letter(c)) begin
          mode       = MODE_WORD;
          open_start = p;
          open_len   = '0;
          letters    = '0;
          add_letter(c);
        end else if (char_is_digit(c)) begin
          mode       = MODE_NUM;
          open_start = p;
          open_len   = 16'd1;
        end else if (c == CH_QUOTE) begin
          mode       = MODE_STR;
          open_start = pn;
          open_len   = '0;
        end else if (c == CH_EQ || c == CH_LT || c == CH_GT || c == CH_BANG) begin
          mode       = MODE_OP;
          open_start = p;
          op_sym     = c;
        end else if (c == CH_LPAREN || c == CH_RPAREN || c == CH_COMMA) begin
          emit_tok(make_tok(KIND_PUNCT, 4'd0, p, 16'd1, c, 1'b0, ovf));
        end else if (c == CH_STAR) begin
          emit_tok(make_tok(KIND_WILD, 4'd0, p, 16'd1, c, 1'b0, ovf));
        end
      end
    end

    foreach (burst[i]) begin
      t                = burst[i];
      t.last           = (i == burst.size() - 1);
      predicted_tokens = {predicted_tokens, t};
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  // Watch both channels; predict on input transfers, compare on output transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) scan_item(cmd_i, ch_i);
      if (out_valid_i && !out_stall_i) begin
        if (predicted_tokens.size() == 0) begin
          $error("token with nothing predicted: kind %0d start %0d",
                 token_kind_i, start_offset_i);
          fails++;
        end else begin
          exp_tok = predicted_tokens.pop_front();
          check_field("token_kind", 16'(exp_tok.kind), 16'(token_kind_i));
          check_field("keyword_code", 16'(exp_tok.kw), 16'(keyword_code_i));
          check_field("start_offset", exp_tok.start, start_offset_i);
          check_field("token_length", exp_tok.len, token_length_i);
          check_field("symbol_char", 16'(exp_tok.sym), 16'(symbol_char_i));
          check_field("with_equals", 16'(exp_tok.eq), 16'(with_equals_i));
          check_field("overflowed", 16'(exp_tok.ovf), 16'(overflowed_i));
          check_field("last_of_run", 16'(exp_tok.last), 16'(last_of_run_i));
        end
      end
    end
    fail_count_o    <= fails;
    pending_count_o <= predicted_tokens.size();
  end

endmodule

// ===== sim/tb_sql_token_scanner_core.sv =====
// Testbench top for the SQL token scanner: query stimulus, output stalls and the verdict.
`timescale 1ns / 1ps

module tb_sql_token_scanner_core;
  import sts_pkg::*;

  typedef struct {
    logic       cmd;
    logic [7:0] ch;
  } scan_in_t;

  typedef enum {PACE_RANDOM, PACE_NONE, PACE_SPARSE} pace_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        cmd_i       = 1'b0;
  logic [7:0]  ch_i        = 8'd0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [2:0]  token_kind_o;
  logic [3:0]  keyword_code_o;
  logic [15:0] start_offset_o;
  logic [15:0] token_length_o;
  logic [7:0]  symbol_char_o;
  logic        with_equals_o;
  logic        overflowed_o;
  logic        last_of_run_o;

  int fail_count;
  int pending_count;

  scan_in_t query_items [$];
  pace_e    pace        = PACE_RANDOM;
  int       hold_cycles = 0;

  string kw_words [12] = '{"SELECT", "INSERT", "DELETE", "FROM", "WHERE", "INTO",
                           "VALUES", "CREATE", "TABLE", "INT", "STRING", "DROP"};

  sql_token_scanner_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .ch_i           (ch_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .keyword_code_o (keyword_code_o),
    .start_offset_o (start_offset_o),
    .token_length_o (token_length_o),
    .symbol_char_o  (symbol_char_o),
    .with_equals_o  (with_equals_o),
    .overflowed_o   (overflowed_o),
    .last_of_run_o  (last_of_run_o)
  );

  sts_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .cmd_i           (cmd_i),
    .ch_i            (ch_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .token_kind_i    (token_kind_o),
    .keyword_code_i  (keyword_code_o),
    .start_offset_i  (start_offset_o),
    .token_length_i  (token_length_o),
    .symbol_char_i   (symbol_char_o),
    .with_equals_i   (with_equals_o),
    .overflowed_i    (overflowed_o),
    .last_of_run_i   (last_of_run_o),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Idle cycles before the next transfer, shared by both sides
  function automatic int draw_gap();
    case (pace)
      PACE_NONE:   return 0;
      PACE_SPARSE: return ($urandom_range(63, 0) == 0) ? int'($urandom_range(16, 1)) : 0;
      default:     return $urandom_range(16, 0);
    endcase
  endfunction

  task automatic add_char(input logic [7:0] c);
    scan_in_t it;
    it.cmd      = 1'b0;
    it.ch       = c;
    query_items = {query_items, it};
  endtask

  task automatic add_end();
    scan_in_t it;
    it.cmd      = 1'b1;
    it.ch       = 8'($urandom_range(255, 0));
    query_items = {query_items, it};
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(1, 0) ? "a" : "A") + 8'($urandom_range(25, 0));
  endfunction

  function automatic logic [7:0] rand_word_char();
    case ($urandom_range(2, 0))
      0:       return rand_letter();
      1:       return "0" + 8'($urandom_range(9, 0));
      default: return CH_UNDER;
    endcase
  endfunction

  // Any byte but the quote, so a string stays open
  function automatic logic [7:0] rand_string_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255, 0));
    return (b == CH_QUOTE) ? 8'h22 : b;
  endfunction

  function automatic logic [7:0] rand_space();
    return $urandom_range(1, 0) ? 8'h20 : 8'h09 + 8'($urandom_range(4, 0));
  endfunction

  // One mostly well-formed token with random content, sometimes noise
  task automatic add_random_token();
    int         r;
    int         n;
    string      s;
    logic [7:0] c;
    r = $urandom_range(99, 0);
    if (r < 25) begin
      s = kw_words[$urandom_range(11, 0)];
      for (int i = 0; i < s.len(); i++) begin
        c = s[i];
        if ($urandom_range(1, 0)) c = c + 8'h20;
        add_char(c);
      end
      // a trailing word character makes it an identifier
      if ($urandom_range(4, 0) == 0) add_char(rand_word_char());
    end else if (r < 40) begin
      add_char(rand_letter());
      n = $urandom_range(9, 0);
      repeat (n) add_char(rand_word_char());
    end else if (r < 52) begin
      n = $urandom_range(6, 1);
      repeat (n) add_char("0" + 8'($urandom_range(9, 0)));
    end else if (r < 62) begin
      add_char(CH_QUOTE);
      n = $urandom_range(6, 0);
      repeat (n) add_char(rand_string_byte());
      if ($urandom_range(9, 0) != 0) add_char(CH_QUOTE);
    end else if (r < 74) begin
      case ($urandom_range(3, 0))
        0:       add_char(CH_EQ);
        1:       add_char(CH_LT);
        2:       add_char(CH_GT);
        default: add_char(CH_BANG);
      endcase
      if ($urandom_range(1, 0)) add_char(CH_EQ);
    end else if (r < 82) begin
      case ($urandom_range(3, 0))
        0:       add_char(CH_LPAREN);
        1:       add_char(CH_RPAREN);
        2:       add_char(CH_COMMA);
        default: add_char(CH_STAR);
      endcase
    end else if (r < 88) begin
      add_char(rand_space());
    end else if (r < 95) begin
      add_char(8'($urandom_range(255, 0)));
    end else begin
      add_end();
    end
    if ($urandom_range(1, 0)) add_char(rand_space());
  endtask

  // Offer queued items one transfer at a time; valid stays up across back-to-back items
  task automatic send_items();
    scan_in_t it;
    int       gap;
    while (query_items.size() > 0) begin
      it  = query_items.pop_front();
      gap = draw_gap();
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      cmd_i      <= it.cmd;
      ch_i       <= it.ch;
      do @(posedge clk_i); while (in_stall_o);
    end
  endtask

  // Output side: stall for the drawn gap, if any, before each token transfer, or hold off long when asked
  initial begin : receiver
    int n;
    wait (rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        n           = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = draw_gap();
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Main stimulus and verdict
  initial begin : stimulus
    int waited;
    waited = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: byte extremes, case-blind keyword, identifier, operators, symbols,
    // unterminated string closed by the end item
    add_char(8'hFF);
    add_char(8'h00);
    add_text("selECT x_1>=9,(*)!<'ab");
    add_end();
    send_items();

    // Random queries in chunks, some with no idling
    for (int chunk = 0; chunk < 8; chunk++) begin
      pace = ($urandom_range(3, 0) == 0) ? PACE_NONE : PACE_RANDOM;
      if (chunk == 3) begin
        // output held off while symbol tokens keep coming, so the input stalls
        pace        = PACE_NONE;
        hold_cycles = 300;
        repeat (60) begin
          case ($urandom_range(3, 0))
            0:       add_char(CH_LPAREN);
            1:       add_char(CH_RPAREN);
            2:       add_char(CH_COMMA);
            default: add_char(CH_STAR);
          endcase
        end
        send_items();
        pace = PACE_RANDOM;
      end
      while (query_items.size() < 140) add_random_token();
      send_items();
    end

    // Closed string, keyword, open operator flushed by end, lone bang
    pace = PACE_SPARSE;
    add_text("'ab' select>");
    add_end();
    add_char(CH_BANG);
    add_end();
    send_items();
    in_valid_i <= 1'b0;

    // Drain, then keep watching for stray tokens before the verdict
    @(posedge clk_i);
    while (pending_count != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_count != 0) $error("%0d predicted tokens never arrived", pending_count);

    if (fail_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #12_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
